// ===== rtl/core/ecal_pkg.sv =====
// Shared types, constants and helper functions of the epoch to BCD calendar block.
package ecal_pkg;

    // Valid window, seconds since 1970-01-01
    localparam logic [31:0] FIRST_VALID   = 32'd946684800;
    // Length of the window 2000-01-01 .. 2099-12-31 23:59:59, plus one
    localparam logic [31:0] WINDOW_SPAN   = 32'd3155760000;

    // Restoring division setups: divisor pre-shifted by (steps - 1)
    localparam int          DAY_STEPS     = 16;
    localparam logic [31:0] DAY_DIV_INIT  = 32'd86400 << (DAY_STEPS - 1);
    localparam int          HOUR_STEPS    = 5;
    localparam logic [31:0] HOUR_DIV_INIT = 32'd3600 << (HOUR_STEPS - 1);
    localparam int          MIN_STEPS     = 6;
    localparam logic [31:0] MIN_DIV_INIT  = 32'd60 << (MIN_STEPS - 1);
    localparam int          WEEK_STEPS    = 16;
    localparam logic [31:0] WEEK_DIV_INIT = 32'd7 << (WEEK_STEPS - 1);

    localparam logic [8:0]  COMMON_YEAR_LEN = 9'd365;
    localparam logic [8:0]  LEAP_YEAR_LEN   = 9'd366;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_APR = 4'd4;
    localparam logic [3:0]  MONTH_JUN = 4'd6;
    localparam logic [3:0]  MONTH_SEP = 4'd9;
    localparam logic [3:0]  MONTH_NOV = 4'd11;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // 2000-01-01 was a Saturday
    localparam logic [2:0]  WEEKDAY_SAT = 3'd6;

    // Binary calendar fields handed to the BCD packer
    typedef struct packed {
        logic       ok;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day0;     // day of month minus one
        logic [2:0] weekday;
        logic [3:0] month;
        logic [6:0] year;     // year minus 2000
    } ecal_bin_t;

    // Packed result fields
    typedef struct packed {
        logic       ok;
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day;
        logic [2:0] weekday;
        logic [4:0] month;
        logic [7:0] year;
    } ecal_bcd_t;

    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    // Two-digit BCD of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] units;
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) tens = 4'(k);
        end
        units = v - 7'({3'b000, tens} * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

// ===== rtl/core/epoch_to_bcd_calendar.sv =====
// Top level: Unix seconds to RTC calendar bytes through one shared subtract/compare unit.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | unix_time[31:0]
//  out     | out_valid / out_stall| valid_res, second_bcd, minute_bcd, hour_bcd,
//          |                      | day_bcd, weekday_code, month_bcd, year_bcd
//
// From acceptance to the output load an item goes through the range checks, four
// restoring divisions and the year and month walks, one year or month per step; an
// out-of-range item goes straight to the load after the failing range check. Every step
// is one pass through the single 33-bit subtractor. The sequencer returns to idle before
// the next item can be taken. in_stall is high from acceptance until the result is
// loaded into the output register; the next item is taken while that result waits
// on out_stall. A finished result waits in its sequencer state only if the previous
// one is still held. Reset clears the sequencer and out_valid.
module epoch_to_bcd_calendar
    import ecal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] unix_time,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [6:0]  second_bcd,
    output logic [6:0]  minute_bcd,
    output logic [5:0]  hour_bcd,
    output logic [5:0]  day_bcd,
    output logic [2:0]  weekday_code,
    output logic [4:0]  month_bcd,
    output logic [7:0]  year_bcd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LO     = 4'd1;   // t - first valid, borrow = too early
    localparam logic [3:0] S_HI     = 4'd2;   // offset vs window span
    localparam logic [3:0] S_DAYDIV = 4'd3;   // offset / 86400
    localparam logic [3:0] S_HRDIV  = 4'd4;   // seconds of day / 3600
    localparam logic [3:0] S_MINDIV = 4'd5;   // remainder / 60
    localparam logic [3:0] S_WKDIV  = 4'd6;   // days % 7
    localparam logic [3:0] S_YEAR   = 4'd7;   // peel whole years
    localparam logic [3:0] S_MONTH  = 4'd8;   // peel whole months
    localparam logic [3:0] S_DONE   = 4'd9;   // load output register

    logic [3:0]  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] div_reg, div_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [2:0]  wd_reg, wd_next;
    logic [6:0]  year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic        ok_reg, ok_next;

    logic        out_valid_reg, out_valid_next;
    ecal_bcd_t   res_reg, res_next;

    // Shared subtract/compare unit
    logic [31:0] sub_opnd;
    logic [32:0] sub_diff;
    logic        borrow;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    // Restoring-division step results
    logic [31:0] step_acc;
    logic [15:0] step_quo;

    ecal_bin_t   bin_fields;
    ecal_bcd_t   bcd_fields;

    // Within 2000..2099 the leap rule reduces to divisibility by 4
    assign leap     = (year_reg[1:0] == 2'b00);
    assign year_len = leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
    assign mon_len  = days_in_month(month_reg, leap);

    always_comb
    begin
        unique case (state_reg)
            S_LO:    sub_opnd = FIRST_VALID;
            S_HI:    sub_opnd = WINDOW_SPAN;
            S_YEAR:  sub_opnd = {23'd0, year_len};
            S_MONTH: sub_opnd = {27'd0, mon_len};
            default: sub_opnd = div_reg;
        endcase
    end

    assign sub_diff = {1'b0, acc_reg} - {1'b0, sub_opnd};
    assign borrow   = sub_diff[32];
    assign step_acc = borrow ? acc_reg : sub_diff[31:0];
    assign step_quo = {quo_reg[14:0], ~borrow};

    assign bin_fields = '{
        ok:      ok_reg,
        sec:     sec_reg,
        min:     min_reg,
        hour:    hour_reg,
        day0:    acc_reg[4:0],
        weekday: wd_reg,
        month:   month_reg,
        year:    year_reg
    };

    ecal_bcd_pack u_bcd_pack (
        .bin (bin_fields),
        .bcd (bcd_fields)
    );

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        days_next  = days_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        wd_next    = wd_reg;
        year_next  = year_reg;
        month_next = month_reg;
        ok_next    = ok_reg;
        res_next   = res_reg;
        // Output register empties when taken
        out_valid_next = out_valid_reg & out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = unix_time;
                    ok_next    = 1'b1;
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                if (borrow)
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next   = sub_diff[31:0];
                    state_next = S_HI;
                end
            end
            S_HI:
            begin
                if (!borrow)
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    div_next   = DAY_DIV_INIT;
                    cnt_next   = 4'(DAY_STEPS - 1);
                    quo_next   = '0;
                    state_next = S_DAYDIV;
                end
            end
            S_DAYDIV, S_HRDIV, S_MINDIV, S_WKDIV:
            begin
                acc_next = step_acc;
                quo_next = step_quo;
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    quo_next = '0;
                    unique case (state_reg)
                        S_DAYDIV:
                        begin
                            days_next  = step_quo;
                            div_next   = HOUR_DIV_INIT;
                            cnt_next   = 4'(HOUR_STEPS - 1);
                            state_next = S_HRDIV;
                        end
                        S_HRDIV:
                        begin
                            hour_next  = step_quo[4:0];
                            div_next   = MIN_DIV_INIT;
                            cnt_next   = 4'(MIN_STEPS - 1);
                            state_next = S_MINDIV;
                        end
                        S_MINDIV:
                        begin
                            min_next   = step_quo[5:0];
                            sec_next   = step_acc[5:0];
                            acc_next   = {16'd0, days_reg};
                            div_next   = WEEK_DIV_INIT;
                            cnt_next   = 4'(WEEK_STEPS - 1);
                            state_next = S_WKDIV;
                        end
                        default:
                        begin
                            // remainder 0 is Saturday, otherwise remainder 1 is Sunday (code 0) and so on
                            wd_next    = (step_acc[2:0] == 3'd0) ? WEEKDAY_SAT
                                                                 : step_acc[2:0] - 3'd1;
                            acc_next   = {16'd0, days_reg};
                            year_next  = '0;
                            state_next = S_YEAR;
                        end
                    endcase
                end
            end
            S_YEAR:
            begin
                if (borrow)
                begin
                    month_next = MONTH_JAN;
                    state_next = S_MONTH;
                end
                else
                begin
                    acc_next  = sub_diff[31:0];
                    year_next = year_reg + 7'd1;
                end
            end
            S_MONTH:
            begin
                if (borrow || month_reg == MONTH_DEC)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next   = sub_diff[31:0];
                    month_next = month_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_next       = bcd_fields;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        days_reg  <= days_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        wd_reg    <= wd_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        ok_reg    <= ok_next;
        res_reg   <= res_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign valid_res    = res_reg.ok;
    assign second_bcd   = res_reg.second;
    assign minute_bcd   = res_reg.minute;
    assign hour_bcd     = res_reg.hour;
    assign day_bcd      = res_reg.day;
    assign weekday_code = res_reg.weekday;
    assign month_bcd    = res_reg.month;
    assign year_bcd     = res_reg.year;

    // An out-of-range result carries only zero bytes
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
            (second_bcd == '0 && minute_bcd == '0 && hour_bcd == '0 && day_bcd == '0 &&
             weekday_code == '0 && month_bcd == '0 && year_bcd == '0))
        else $error("invalid result with nonzero bytes");

    // A valid date has nonzero day and month and a real weekday
    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            (day_bcd != '0 && month_bcd != '0 && weekday_code <= WEEKDAY_SAT))
        else $error("valid result with impossible date");

    // Year walk never leaves the century
    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR) |-> (year_reg <= 7'd99))
        else $error("year walk past 2099");

    // Month walk stays in January..December
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (month_reg >= MONTH_JAN && month_reg <= MONTH_DEC))
        else $error("month walk out of range");

    // Accepted item starts with the lower range check
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_LO))
        else $error("accepted item did not start the sequence");

endmodule

// ===== rtl/core/ecal_bcd_pack.sv =====
// Packs the binary calendar fields into BCD bytes; zeroes all on an out-of-range time.
module ecal_bcd_pack
    import ecal_pkg::*;
(
    input  ecal_bin_t bin,
    output ecal_bcd_t bcd
);

    logic [7:0] sec_b;
    logic [7:0] min_b;
    logic [7:0] hour_b;
    logic [7:0] day_b;
    logic [7:0] month_b;
    logic [7:0] year_b;
    logic [6:0] day1;

    assign day1    = {2'b00, bin.day0} + 7'd1;
    assign sec_b   = to_bcd({1'b0, bin.sec});
    assign min_b   = to_bcd({1'b0, bin.min});
    assign hour_b  = to_bcd({2'b00, bin.hour});
    assign day_b   = to_bcd(day1);
    assign month_b = to_bcd({3'b000, bin.month});
    assign year_b  = to_bcd(bin.year);

    always_comb
    begin
        if (bin.ok)
        begin
            bcd.ok      = 1'b1;
            bcd.second  = sec_b[6:0];
            bcd.minute  = min_b[6:0];
            bcd.hour    = hour_b[5:0];
            bcd.day     = day_b[5:0];
            bcd.weekday = bin.weekday;
            bcd.month   = month_b[4:0];
            bcd.year    = year_b;
        end
        else
        begin
            bcd = '0;
        end
    end

endmodule

// ===== sim/epoch_to_bcd_calendar_tb.sv =====
// Testbench: Unix seconds to BCD calendar converter, self-checking against its own calendar predictor.
`timescale 1ns / 100ps

module epoch_to_bcd_calendar_tb;

    // Window of times the block converts; anything outside gives an all-zero item
    localparam logic [31:0] WINDOW_FIRST = 32'd946684800;   // 2000-01-01 00:00:00
    localparam logic [31:0] WINDOW_LAST  = 32'd4102444799;  // 2099-12-31 23:59:59
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned FIRST_DAY    = 10957;           // day index of 2000-01-01
    localparam int unsigned LAST_DAY     = 47481;           // day index of 2099-12-31

    localparam int RANDOM_ITEMS = 1200;
    // Receiver hold-off: long enough to fill the output register and the sequencer,
    // so in_stall backs up onto the sender.
    localparam int HOLD_START   = 2000;
    localparam int HOLD_CYCLES  = 800;
    // Items in this index range go through with no idling on either side
    localparam int STEADY_FIRST = 500;
    localparam int STEADY_LAST  = 800;
    localparam int DRAIN_CYCLES = 400;
    // Cycles with no handshake on either channel before the run is declared hung;
    // covers the hold-off plus the slowest item several times over.
    localparam int HANG_LIMIT   = 5000;

    // Expected calendar bytes, one per input item
    typedef struct packed {
        logic       ok;
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day;
        logic [2:0] weekday;
        logic [4:0] month;
        logic [7:0] year;
    } cal_bytes_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [31:0] unix_time = '0;

    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        valid_res;
    logic [6:0]  second_bcd;
    logic [6:0]  minute_bcd;
    logic [5:0]  hour_bcd;
    logic [5:0]  day_bcd;
    logic [2:0]  weekday_code;
    logic [4:0]  month_bcd;
    logic [7:0]  year_bcd;

    logic [31:0] pending_times[$];   // times still to be offered to the block
    cal_bytes_t  expected_cal[$];    // predicted bytes of accepted items, oldest first
    cal_bytes_t  want;

    int n_offered   = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_total     = 0;
    int rx_cycles   = 0;
    int idle_cycles = 0;
    bit failed      = 1'b0;

    epoch_to_bcd_calendar u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .unix_time    (unix_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .valid_res    (valid_res),
        .second_bcd   (second_bcd),
        .minute_bcd   (minute_bcd),
        .hour_bcd     (hour_bcd),
        .day_bcd      (day_bcd),
        .weekday_code (weekday_code),
        .month_bcd    (month_bcd),
        .year_bcd     (year_bcd)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gregorian rule: every 4th year, except centuries not divisible by 400
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Two BCD digits, tens in the high nibble
    function automatic logic [7:0] bcd2(input int unsigned v);
        return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    // Predicted calendar bytes for one time value
    function automatic cal_bytes_t calendar_of(input logic [31:0] t);
        cal_bytes_t  r;
        int unsigned days;
        int unsigned secs;
        int unsigned year;
        int unsigned month;
        int unsigned span;
        r = '0;
        if (t < WINDOW_FIRST || t > WINDOW_LAST)
        begin
            return r;
        end
        days = t / SECS_PER_DAY;
        secs = t % SECS_PER_DAY;
        // 1970-01-01 was a Thursday
        r.weekday = 3'((days + 4) % 7);
        year = 1970;
        forever
        begin
            span = is_leap(year) ? 366 : 365;
            if (days < span) break;
            days -= span;
            year++;
        end
        month = 1;
        while (month < 12)
        begin
            case (month)
                2:          span = is_leap(year) ? 29 : 28;
                4, 6, 9, 11: span = 30;
                default:    span = 31;
            endcase
            if (days < span) break;
            days -= span;
            month++;
        end
        r.ok     = 1'b1;
        r.second = 7'(bcd2(secs % 60));
        r.minute = 7'(bcd2((secs / 60) % 60));
        r.hour   = 6'(bcd2(secs / 3600));
        r.day    = 6'(bcd2(days + 1));
        r.month  = 5'(bcd2(month));
        r.year   = bcd2(year - 2000);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // Sender: offers the next pending time at the falling edge once the current
    // item has been taken; idles about 13% of the time outside the steady range.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || n_accepted == n_offered))
        begin
            if (pending_times.size() > 0 &&
                ((n_offered >= STEADY_FIRST && n_offered < STEADY_LAST) ||
                 $urandom_range(99) >= 13))
            begin
                unix_time <= pending_times.pop_front();
                in_valid  <= 1'b1;
                n_offered++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off counted here, none in the steady range
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
                out_stall <= 1'b1;
            else if (n_checked >= STEADY_FIRST && n_checked < STEADY_LAST)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 13);
        end
    end

    // Both channels sampled at the rising edge: predict on input accept,
    // compare on output accept. The watchdog tracks cycles with no handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                expected_cal.push_back(calendar_of(unix_time));
                n_accepted++;
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                n_checked++;
                if (expected_cal.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got valid_res %0b",
                             $time, valid_res);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_cal.pop_front();
                    check_field("valid_res",    want.ok,      valid_res);
                    check_field("second_bcd",   want.second,  second_bcd);
                    check_field("minute_bcd",   want.minute,  minute_bcd);
                    check_field("hour_bcd",     want.hour,    hour_bcd);
                    check_field("day_bcd",      want.day,     day_bcd);
                    check_field("weekday_code", want.weekday, weekday_code);
                    check_field("month_bcd",    want.month,   month_bcd);
                    check_field("year_bcd",     want.year,    year_bcd);
                end
            end
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned day_idx;

        // Directed: range edges on both sides, extremes of the input word,
        // leap days, year and month rollovers, the 31-bit rollover
        pending_times.push_back(32'd0);
        pending_times.push_back(WINDOW_FIRST - 32'd1);     // last second before 2000
        pending_times.push_back(WINDOW_FIRST);             // 2000-01-01, a Saturday
        pending_times.push_back(WINDOW_FIRST + 32'd1);
        pending_times.push_back(32'd951782399);            // 2000-02-28 23:59:59
        pending_times.push_back(32'd951782400);            // 2000-02-29, century leap day
        pending_times.push_back(32'd951868800);            // 2000-03-01
        pending_times.push_back(32'd978307199);            // 2000-12-31 23:59:59
        pending_times.push_back(32'd978307200);            // 2001-01-01
        pending_times.push_back(32'd983404800);            // 2001-03-01, non-leap
        pending_times.push_back(32'd1000000000);
        pending_times.push_back(32'd1709164800);           // 2024-02-29
        pending_times.push_back(32'd1719791999);           // 2024-06-30 23:59:59
        pending_times.push_back(32'd2147483647);           // largest positive 32-bit time
        pending_times.push_back(32'd2147483648);
        pending_times.push_back(32'd3000000000);
        pending_times.push_back(32'd4038825600);           // 2097-12-25
        pending_times.push_back(32'd4102358400);           // 2099-12-31 00:00:00
        pending_times.push_back(WINDOW_LAST);              // last second of 2099
        pending_times.push_back(WINDOW_LAST + 32'd1);      // first second of 2100
        pending_times.push_back(32'h8000_0000);
        pending_times.push_back(32'hFFFF_FFFF);

        // Random: mostly inside the window, some hugging its edges or a
        // midnight, some anywhere in the 32-bit space
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                pending_times.push_back($urandom_range(WINDOW_LAST, WINDOW_FIRST));
            else if (pick < 80)
                pending_times.push_back(($urandom_range(1) ? WINDOW_FIRST : WINDOW_LAST)
                                        - 32'd2 + $urandom_range(4));
            else if (pick < 90)
            begin
                day_idx = $urandom_range(LAST_DAY, FIRST_DAY);
                pending_times.push_back(day_idx * SECS_PER_DAY +
                                        ($urandom_range(1) ? 0 : SECS_PER_DAY - 1));
            end
            else
                pending_times.push_back($urandom());
        end
        n_total = pending_times.size();

        // Reset held, then released at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_accepted == n_total && expected_cal.size() == 0);
        // Let any stray item show up before calling it
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cal.size() != 0)
            failed = 1'b1;

        if (!failed)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
